// File: hw/rtl/sbus_frame_receiver_macros.svh
// Assertion macros shared by the frame receiver RTL.
`ifndef SBUS_FRAME_RECEIVER_MACROS_SVH
`define SBUS_FRAME_RECEIVER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Condition that must hold at every clock edge outside reset.
`define SBUS_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("sbus assertion failed");
// Consequence that must hold in the cycle after the trigger.
`define SBUS_ASSERT_NEXT(lbl, clk, rst_n, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("sbus assertion failed");
`else
`define SBUS_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define SBUS_ASSERT_NEXT(lbl, clk, rst_n, trig, cons)
`endif
`endif

// File: hw/rtl/sbus_pkg.sv
// Shared constants and types of the frame receiver.
`timescale 1ns / 1ps
`default_nettype none
package sbus_pkg;

  localparam int FRAME_BYTES_DEF = 25;
  localparam int POS_W           = $clog2(FRAME_BYTES_DEF);
  localparam int QUEUE_DEPTH     = 2;
  localparam int NUM_CHANNELS    = 8;
  localparam int CHAN_W          = 11;
  localparam int PAYLOAD_BYTES   = 11;

  localparam logic [7:0] START_BYTE       = 8'h0f;
  localparam logic [7:0] END_MARK_INVALID = 8'hff;
  localparam logic [7:0] END_BYTE_OK      = 8'h00;

  // What the back end does with one item
  typedef enum logic [1:0] {
    OP_DROP  = 2'd0,
    OP_WRITE = 2'd1,
    OP_START = 2'd2
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [POS_W-1:0] addr;
    logic [7:0]       data;
  } cmd_t;

endpackage
`default_nettype wire

// File: hw/rtl/sbus_front.sv
// Front end: tracks the write position and classifies each received byte.
`timescale 1ns / 1ps
`default_nettype none
module sbus_front import sbus_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] rx_byte,
  output cmd_t            cmd
);

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;

  // Start byte restarts, other bytes advance until the end byte, then drop
  always_comb begin
    cmd.data = rx_byte;
    cmd.addr = pos_r + 1'b1;
    pos_nxt  = pos_r;
    if (rx_byte == START_BYTE) begin
      cmd.op  = OP_START;
      cmd.addr = '0;
      pos_nxt = '0;
    end else if (pos_r < LAST_POS) begin
      cmd.op  = OP_WRITE;
      pos_nxt = pos_r + 1'b1;
    end else begin
      cmd.op  = OP_DROP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/sbus_cmd_queue.sv
// Short queue of classified items between front and back end.
`timescale 1ns / 1ps
`default_nettype none
`include "sbus_frame_receiver_macros.svh"
module sbus_cmd_queue import sbus_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output cmd_t      head_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  // Storage needs no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  `SBUS_ASSERT_ALWAYS(a_no_overflow, clk, rst_n, !(push && full && !pop))
  `SBUS_ASSERT_ALWAYS(a_no_underflow, clk, rst_n, !(pop && !head_valid))
  `SBUS_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CNT_W'(DEPTH))

endmodule
`default_nettype wire

// File: hw/rtl/sbus_back.sv
// Back end: frame store update, channel unpack and output register.
`timescale 1ns / 1ps
`default_nettype none
`include "sbus_frame_receiver_macros.svh"
module sbus_back import sbus_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    head_valid,
  input  wire cmd_t    head_cmd,
  output logic         pop,
  output logic         out_valid,
  input  wire logic    out_stall,
  output logic         out_frame_valid,
  output logic [CHAN_W-1:0] out_chan [NUM_CHANNELS]
);

  logic [7:0] store_r   [FRAME_BYTES];
  logic [7:0] store_nxt [FRAME_BYTES];
  logic [8*PAYLOAD_BYTES-1:0] payload;
  logic       out_valid_r;
  logic       frame_valid_r;
  logic       frame_valid_nxt;
  logic [CHAN_W-1:0] chan_r [NUM_CHANNELS];

  // Take the next item when the output slot is empty or being emptied
  assign pop = head_valid && (!out_valid_r || !out_stall);

  // Store after this item
  always_comb begin
    store_nxt = store_r;
    case (head_cmd.op)
      OP_START: begin
        store_nxt[0]             = START_BYTE;
        store_nxt[FRAME_BYTES-1] = END_MARK_INVALID;
      end
      OP_WRITE: begin
        store_nxt[head_cmd.addr] = head_cmd.data;
      end
      default: begin
      end
    endcase
  end

  // Little-endian payload from bytes 1 onward
  always_comb begin
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      payload[8*i +: 8] = store_nxt[i + 1];
    end
  end

  assign frame_valid_nxt = (store_nxt[0] == START_BYTE) &&
                           (store_nxt[FRAME_BYTES-1] == END_BYTE_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < FRAME_BYTES; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      if (pop) begin
        out_valid_r <= 1'b1;
        store_r     <= store_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, loaded with the store
  always_ff @(posedge clk) begin
    if (pop) begin
      frame_valid_r <= frame_valid_nxt;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        chan_r[k] <= payload[k*CHAN_W +: CHAN_W];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_valid = frame_valid_r;
  assign out_chan        = chan_r;

  `SBUS_ASSERT_NEXT(a_pop_fills_slot, clk, rst_n, pop, out_valid_r)
  `SBUS_ASSERT_NEXT(a_start_marks_end, clk, rst_n, pop && (head_cmd.op == OP_START),
    (store_r[0] == START_BYTE) && (store_r[FRAME_BYTES-1] == END_MARK_INVALID))
  `SBUS_ASSERT_ALWAYS(a_flag_matches_store, clk, rst_n, !out_valid_r ||
    (frame_valid_r == ((store_r[0] == START_BYTE) &&
    (store_r[FRAME_BYTES-1] == END_BYTE_OK))))

endmodule
`default_nettype wire

// File: hw/rtl/sbus_frame_receiver.sv
// Serial frame receiver: byte in, frame flag and eight channels out.
//
// Input channel: in_valid / in_stall carry one received byte per item
// (in_rx_byte). Output channel: out_valid / out_stall carry one result per
// byte: out_frame_valid and the eight 11-bit channels out_channel_0..7,
// taken from the frame store after that byte was written.
// Throughput: one byte per cycle while in_stall is low. A result passes
// through the item queue between the classifying front end and the back
// end, then through the output register, before it is offered on out_valid.
// A start byte 0x0f restarts the frame at byte 0; other bytes fill bytes
// 1 to 24 in turn and are dropped once byte 24 is written.
// Reset (rst_n low, synchronous) clears the frame store to zeros, the
// write position to 0, the queue and out_valid (not the result data).
// When the receiver stalls, the result holds; the queue keeps taking
// bytes until it is full, then in_stall rises until the output drains.
`timescale 1ns / 1ps
`default_nettype none
module sbus_frame_receiver import sbus_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int Q_DEPTH     = QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_rx_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_frame_valid,
  output logic [CHAN_W-1:0]      out_channel_0,
  output logic [CHAN_W-1:0]      out_channel_1,
  output logic [CHAN_W-1:0]      out_channel_2,
  output logic [CHAN_W-1:0]      out_channel_3,
  output logic [CHAN_W-1:0]      out_channel_4,
  output logic [CHAN_W-1:0]      out_channel_5,
  output logic [CHAN_W-1:0]      out_channel_6,
  output logic [CHAN_W-1:0]      out_channel_7
);

  logic accept;
  logic q_full;
  logic q_pop;
  logic head_valid;
  cmd_t front_cmd;
  cmd_t head_cmd;
  logic [CHAN_W-1:0] chan [NUM_CHANNELS];

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  sbus_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_rx_byte),
    .cmd     (front_cmd)
  );

  sbus_cmd_queue #(.DEPTH(Q_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_cmd   (front_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  sbus_back #(.FRAME_BYTES(FRAME_BYTES)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_cmd        (head_cmd),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame_valid (out_frame_valid),
    .out_chan        (chan)
  );

  assign out_channel_0 = chan[0];
  assign out_channel_1 = chan[1];
  assign out_channel_2 = chan[2];
  assign out_channel_3 = chan[3];
  assign out_channel_4 = chan[4];
  assign out_channel_5 = chan[5];
  assign out_channel_6 = chan[6];
  assign out_channel_7 = chan[7];

endmodule
`default_nettype wire
